### rtl/cfr_pkg.sv
package cfr_pkg;

  localparam int NUM_BANDS = 4;
  localparam int MAX_BANDS = 4;

  localparam logic [16:0] ONE_Q16 = 17'd65536;

  localparam logic signed [31:0] ETA_RESET  = 32'sd65536;
  localparam logic [30:0]        FOUR_RESET = 31'd0;

  // Register kind selected by the low index bit
  localparam logic REG_KIND_ETA  = 1'b0;
  localparam logic REG_KIND_FOUR = 1'b1;

  localparam int SQRT_CELLS = 32;
  localparam int DIV_CELLS  = 17;
  localparam int AUX_W      = 67;

  // top input stage + band pipeline
  localparam int BAND_LAT = 2 + SQRT_CELLS + 1 + SQRT_CELLS + 4 + DIV_CELLS + 2;
  localparam int LAT      = 1 + BAND_LAT;

  typedef struct packed {
    logic [63:0]      rad;
    logic [33:0]      rem;
    logic [31:0]      root;
    logic [AUX_W-1:0] aux;
  } sqrt_stage_t;

  typedef struct packed {
    logic [34:0] rem;
    logic [33:0] den;
    logic [16:0] quo;
    logic        den_zero;
  } div_stage_t;

endpackage

### rtl/cfr_sqrt_cell.sv
module cfr_sqrt_cell
  import cfr_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  sqrt_stage_t stage_i,
  output sqrt_stage_t stage_o
);

  logic [33:0] rem_sh;
  logic [33:0] trial;
  logic        ge;
  sqrt_stage_t stage_d;
  sqrt_stage_t stage_q;

  // one root bit: bring in two radicand bits, try root*4+1
  always_comb begin
    rem_sh       = {stage_i.rem[31:0], stage_i.rad[63:62]};
    trial        = {stage_i.root, 2'b01};
    ge           = (rem_sh >= trial);
    stage_d.rad  = {stage_i.rad[61:0], 2'b00};
    stage_d.rem  = ge ? (rem_sh - trial) : rem_sh;
    stage_d.root = {stage_i.root[30:0], ge};
    stage_d.aux  = stage_i.aux;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

### rtl/cfr_div_cell.sv
module cfr_div_cell
  import cfr_pkg::*;
(
  input  logic       clk_i,
  input  logic       en_i,
  input  div_stage_t stage_i,
  output div_stage_t stage_o
);

  logic        ge;
  logic [34:0] diff;
  logic [33:0] rem_nx;
  div_stage_t  stage_d;
  div_stage_t  stage_q;

  // restoring step; partial remainder stays below twice the divisor
  always_comb begin
    ge               = (stage_i.rem >= {1'b0, stage_i.den});
    diff             = stage_i.rem - {1'b0, stage_i.den};
    rem_nx           = ge ? diff[33:0] : stage_i.rem[33:0];
    stage_d.rem      = {rem_nx, 1'b0};
    stage_d.den      = stage_i.den;
    stage_d.quo      = {stage_i.quo[15:0], ge};
    stage_d.den_zero = stage_i.den_zero;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

### rtl/cfr_band.sv
module cfr_band
  import cfr_pkg::*;
(
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [16:0]        c_i,
  input  logic [16:0]        c2_i,
  input  logic signed [31:0] eta_i,
  input  logic [30:0]        four_i,
  output logic [16:0]        refl_o
);

  // t0 and its magnitude
  logic [16:0]        s2_in;
  logic signed [32:0] t0_d;
  logic signed [32:0] t0_neg;
  logic signed [32:0] t0_q;
  logic [31:0]        mag_d;
  logic [31:0]        mag_q;
  logic [16:0]        c_q;
  logic [16:0]        c2_q;
  logic [30:0]        f_q;

  always_comb begin
    s2_in  = ONE_Q16 - c2_i;
    t0_d   = $signed({eta_i[31], eta_i}) - $signed({16'b0, s2_in});
    t0_neg = -t0_d;
    mag_d  = t0_d[32] ? t0_neg[31:0] : t0_d[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t0_q  <= t0_d;
      mag_q <= mag_d;
      c_q   <= c_i;
      c2_q  <= c2_i;
      f_q   <= four_i;
    end
  end

  // first root: a2+b2
  sqrt_stage_t sq1 [SQRT_CELLS+1];
  sqrt_stage_t sq1_d;
  logic [63:0] mag_sqr;

  always_comb begin
    mag_sqr    = mag_q * mag_q;
    sq1_d.rad  = mag_sqr + {17'b0, f_q, 16'b0};
    sq1_d.rem  = '0;
    sq1_d.root = '0;
    sq1_d.aux  = {t0_q, c_q, c2_q};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq1[0] <= sq1_d;
    end
  end

  for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_sq1
    cfr_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en_i),
      .stage_i(sq1[i]),
      .stage_o(sq1[i+1])
    );
  end

  // second root: a = sqrt(((a2b2 + t0) >> 1) << 16)
  sqrt_stage_t        sq2 [SQRT_CELLS+1];
  sqrt_stage_t        sq2_d;
  logic signed [32:0] r1_t0;
  logic signed [33:0] r1_sum;

  always_comb begin
    r1_t0      = $signed(sq1[SQRT_CELLS].aux[66:34]);
    r1_sum     = $signed({2'b0, sq1[SQRT_CELLS].root}) + $signed({r1_t0[32], r1_t0});
    sq2_d.rad  = {15'b0, r1_sum[33:1], 16'b0};
    sq2_d.rem  = '0;
    sq2_d.root = '0;
    sq2_d.aux  = {1'b0, sq1[SQRT_CELLS].root, sq1[SQRT_CELLS].aux[33:0]};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq2[0] <= sq2_d;
    end
  end

  for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_sq2
    cfr_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en_i),
      .stage_i(sq2[i]),
      .stage_o(sq2[i+1])
    );
  end

  // products
  logic [24:0] p_a;
  logic [31:0] p_a2b2;
  logic [16:0] p_c;
  logic [16:0] p_c2;
  logic [16:0] p_s2;
  logic [41:0] pac_q;
  logic [48:0] pa2_q;
  logic [33:0] ps2_q;
  logic [32:0] t1_q;
  logic [16:0] s2_q;

  always_comb begin
    p_a    = sq2[SQRT_CELLS].root[24:0];
    p_a2b2 = sq2[SQRT_CELLS].aux[65:34];
    p_c    = sq2[SQRT_CELLS].aux[33:17];
    p_c2   = sq2[SQRT_CELLS].aux[16:0];
    p_s2   = ONE_Q16 - p_c2;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pac_q <= p_a * p_c;
      pa2_q <= p_a2b2 * p_c2;
      ps2_q <= p_s2 * p_s2;
      t1_q  <= {1'b0, p_a2b2} + {16'b0, p_c2};
      s2_q  <= p_s2;
    end
  end

  // t2 = 2ac >> 16, t3
  logic [32:0] t1x_q;
  logic [26:0] t2x_q;
  logic [33:0] t3x_q;
  logic [16:0] s2x_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1x_q <= t1_q;
      t2x_q <= pac_q[41:15];
      t3x_q <= {1'b0, pa2_q[48:16]} + {16'b0, ps2_q[33:16]};
      s2x_q <= s2_q;
    end
  end

  // t4
  logic [43:0] t4_prod;
  logic [32:0] t1y_q;
  logic [26:0] t2y_q;
  logic [33:0] t3y_q;
  logic [27:0] t4y_q;

  assign t4_prod = t2x_q * s2x_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1y_q <= t1x_q;
      t2y_q <= t2x_q;
      t3y_q <= t3x_q;
      t4y_q <= t4_prod[43:16];
    end
  end

  // divider setup; negative numerators count as zero
  div_stage_t  dv1 [DIV_CELLS+1];
  div_stage_t  dv2 [DIV_CELLS+1];
  div_stage_t  dv1_d;
  div_stage_t  dv2_d;
  logic [32:0] t2_ext;
  logic [33:0] t4_ext;

  always_comb begin
    t2_ext         = {6'b0, t2y_q};
    t4_ext         = {6'b0, t4y_q};
    dv1_d.den      = {1'b0, t1y_q} + {1'b0, t2_ext};
    dv1_d.rem      = (t1y_q > t2_ext) ? {2'b0, t1y_q - t2_ext} : '0;
    dv1_d.quo      = '0;
    dv1_d.den_zero = (dv1_d.den == '0);
    dv2_d.den      = t3y_q + t4_ext;
    dv2_d.rem      = (t3y_q > t4_ext) ? {1'b0, t3y_q - t4_ext} : '0;
    dv2_d.quo      = '0;
    dv2_d.den_zero = (dv2_d.den == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dv1[0] <= dv1_d;
      dv2[0] <= dv2_d;
    end
  end

  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
    cfr_div_cell u_rs (
      .clk_i  (clk_i),
      .en_i   (en_i),
      .stage_i(dv1[i]),
      .stage_o(dv1[i+1])
    );
    cfr_div_cell u_rp (
      .clk_i  (clk_i),
      .en_i   (en_i),
      .stage_i(dv2[i]),
      .stage_o(dv2[i+1])
    );
  end

  // Rs, Rp and the average
  logic [16:0] rs;
  logic [16:0] ratio;
  logic [16:0] rs_q;
  logic [33:0] rp_q;
  logic [17:0] avg;
  logic [16:0] refl_q;

  always_comb begin
    rs    = dv1[DIV_CELLS].den_zero ? ONE_Q16 : dv1[DIV_CELLS].quo;
    ratio = dv2[DIV_CELLS].den_zero ? ONE_Q16 : dv2[DIV_CELLS].quo;
    avg   = {1'b0, rs_q} + {1'b0, rp_q[32:16]};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rs_q   <= rs;
      rp_q   <= rs * ratio;
      refl_q <= avg[17:1];
    end
  end

  assign refl_o = refl_q;

endmodule

### rtl/conductor_fresnel_reflectance_top.sv
// Conductor Fresnel reflectance, four spectral bands, fully pipelined: one cosine
// is taken every cycle unless the output stalls. Each band runs two 32-cell
// square-root chains (one root bit per cell) and two 17-cell divider chains (one
// quotient bit per cell); these chains make up most of the pipeline. The whole
// pipeline holds while a finished result is stalled at the output. Band terms are
// written through the configuration port at index 2*band (eta^2-k^2) and
// 2*band+1 (4 eta^2 k^2); write only while the pipeline is empty.
module conductor_fresnel_reflectance_top
  import cfr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [17:0] cos_incident_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [16:0]        reflect_band0_o,
  output logic [16:0]        reflect_band1_o,
  output logic [16:0]        reflect_band2_o,
  output logic [16:0]        reflect_band3_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  logic signed [31:0] eta_q  [MAX_BANDS];
  logic [30:0]        four_q [MAX_BANDS];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < MAX_BANDS; b++) begin
        eta_q[b]  <= ETA_RESET;
        four_q[b] <= FOUR_RESET;
      end
    end else if (cfg_valid_i) begin
      if (cfg_index_i[0] == REG_KIND_ETA) begin
        eta_q[cfg_index_i[2:1]] <= cfg_data_i;
      end else begin
        four_q[cfg_index_i[2:1]] <= cfg_data_i[30:0];
      end
    end
  end

  // valid chain, all stages advance together
  logic [LAT-1:0] vld_q;
  logic           adv;

  assign adv         = !(vld_q[LAT-1] && out_stall_i);
  assign in_stall_o  = !adv;
  assign out_valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // |cos| clamped to one, and its square
  logic signed [17:0] cos_neg;
  logic [17:0]        cos_mag;
  logic [16:0]        c;
  logic [33:0]        c_sqr;
  logic [16:0]        c_q;
  logic [16:0]        c2_q;

  always_comb begin
    cos_neg = -cos_incident_i;
    cos_mag = cos_incident_i[17] ? cos_neg : cos_incident_i;
    c       = (cos_mag > {1'b0, ONE_Q16}) ? ONE_Q16 : cos_mag[16:0];
    c_sqr   = c * c;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_q  <= c;
      c2_q <= c_sqr[32:16];
    end
  end

  logic [16:0] refl [MAX_BANDS];

  for (genvar b = 0; b < MAX_BANDS; b++) begin : g_band
    if (b < NUM_BANDS) begin : g_on
      cfr_band u_band (
        .clk_i (clk_i),
        .en_i  (adv),
        .c_i   (c_q),
        .c2_i  (c2_q),
        .eta_i (eta_q[b]),
        .four_i(four_q[b]),
        .refl_o(refl[b])
      );
    end else begin : g_off
      assign refl[b] = '0;
    end
  end

  assign reflect_band0_o = refl[0];
  assign reflect_band1_o = refl[1];
  assign reflect_band2_o = refl[2];
  assign reflect_band3_o = refl[3];

endmodule

### bench/tb_top.sv
module tb_top;
  import cfr_pkg::*;

  typedef struct packed {
    logic [16:0] r0;
    logic [16:0] r1;
    logic [16:0] r2;
    logic [16:0] r3;
  } reflect_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [17:0] cos_incident_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [16:0]        reflect_band0_o, reflect_band1_o, reflect_band2_o, reflect_band3_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [31:0]        cfg_data_i = '0;

  conductor_fresnel_reflectance_top i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // band terms as the predictor sees them
  logic signed [63:0] eta_term [MAX_BANDS];
  logic [63:0]        four_term [MAX_BANDS];

  logic [17:0]  cos_pending [$];
  reflect_t     reflect_expected [$];
  int           send_idle_pct, recv_idle_pct;
  int           mismatches;
  longint       cycle_count;
  logic         timed_out;
  logic         in_accepted = 1'b0;

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] root, bit_w;
    root = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= root + bit_w) begin
        v = v - (root + bit_w);
        root = (root >> 1) + bit_w;
      end else begin
        root = root >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return root;
  endfunction

  function automatic logic [16:0] band_reflectance(input logic signed [63:0] e,
      input logic [63:0] f, input logic [63:0] c, input logic [63:0] c2,
      input logic [63:0] s2);
    logic signed [63:0] t0;
    logic [63:0] mag, a2b2, v, a, t1, t2, t3, t4, rs, p, den, num;
    t0 = e - $signed(s2);
    mag = (t0 < 0) ? -t0 : t0;
    a2b2 = int_sqrt(mag * mag + (f << 16));
    v = ($signed(a2b2) + t0) >>> 1;
    a = int_sqrt(v << 16);
    t1 = a2b2 + c2;
    t2 = (2 * a * c) >> 16;
    t3 = ((a2b2 * c2) >> 16) + ((s2 * s2) >> 16);
    t4 = (t2 * s2) >> 16;
    den = t1 + t2;
    if (den == 0) rs = 65536;
    else begin
      num = (t1 > t2) ? t1 - t2 : 0;
      rs = (num << 16) / den;
    end
    den = t3 + t4;
    if (den == 0) p = 65536;
    else begin
      num = (t3 > t4) ? t3 - t4 : 0;
      p = (num << 16) / den;
    end
    return 17'((rs + ((rs * p) >> 16)) >> 1);
  endfunction

  function automatic reflect_t predict_reflectance(input logic signed [17:0] cos_in);
    logic [63:0] c, c2, s2;
    logic [16:0] r [MAX_BANDS];
    c = (cos_in < 0) ? 64'(-64'(cos_in)) : 64'(cos_in);
    if (c > 65536) c = 65536;
    c2 = (c * c) >> 16;
    s2 = 65536 - c2;
    for (int b = 0; b < MAX_BANDS; b++)
      r[b] = (b < NUM_BANDS) ? band_reflectance(eta_term[b], four_term[b], c, c2, s2) : '0;
    return {r[0], r[1], r[2], r[3]};
  endfunction

  // transfer seen at the last rising edge
  always @(posedge clk_i) begin
    in_accepted <= in_valid_i && !in_stall_o;
  end

  // driver: one transfer per accepted cycle, payload held while stalled
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_accepted) begin
        if (cos_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          cos_incident_i <= cos_pending.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // input monitor computes expectations; output monitor compares
  always @(posedge clk_i) begin
    reflect_t got, want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        reflect_expected.push_back(predict_reflectance(cos_incident_i));
      if (out_valid_o && !out_stall_i) begin
        got = {reflect_band0_o, reflect_band1_o, reflect_band2_o, reflect_band3_o};
        if (reflect_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          want = reflect_expected.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                       want.r0, want.r1, want.r2, want.r3, got.r0, got.r1, got.r2, got.r3);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > 2000000) begin
      $display("[conductor_fresnel_reflectance_top] ERROR");
      $finish;
    end
  end

  task automatic write_reg(input int idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= 3'(idx);
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx[0] == REG_KIND_ETA) eta_term[idx >> 1] = $signed(data);
    else four_term[idx >> 1] = {33'd0, data[30:0]};
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain_pipeline();
    while (cos_pending.size() > 0 || in_valid_i || reflect_expected.size() > 0)
      @(posedge clk_i);
    repeat (LAT + 5) @(posedge clk_i);
  endtask

  function automatic logic [17:0] random_cos();
    case ($urandom_range(9))
      0: return 18'($urandom_range(65536));
      1: return 18'($urandom);
      2: return 18'(-$signed(18'($urandom_range(65536))));
      default: return 18'($urandom_range(131071) - 65536);
    endcase
  endfunction

  function automatic logic [31:0] random_eta();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      default: return 32'($urandom_range(20 * 65536)) - 32'(65536);
    endcase
  endfunction

  function automatic logic [31:0] random_four();
    case ($urandom_range(4))
      0: return {1'b0, 31'($urandom)};
      1: return 32'h7fff_ffff;
      2: return 0;
      default: return 32'($urandom_range(400 * 65536));
    endcase
  endfunction

  initial begin
    logic [17:0] directed [];
    directed = '{18'd0, 18'd1, 18'd65535, 18'd65536, 18'h1ffff, 18'h20000,
                 18'h3ffff, 18'(-65536), 18'(-1), 18'd32768, 18'd46341,
                 18'd65537, 18'h10000 ^ 18'h2aaaa, 18'h15555};
    for (int b = 0; b < MAX_BANDS; b++) begin
      eta_term[b] = 64'(ETA_RESET);
      four_term[b] = 64'(FOUR_RESET);
    end
    mismatches = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset terms first, then extremes and random settings
    foreach (directed[i]) cos_pending.push_back(directed[i]);
    drain_pipeline();
    for (int phase = 0; phase < 9; phase++) begin
      for (int r = 0; r < 2 * MAX_BANDS; r++) begin
        logic [31:0] d;
        if (phase == 0) d = r[0] ? 32'h7fff_ffff : 32'h8000_0000;
        else if (phase == 1) d = r[0] ? 32'h0 : 32'h7fff_ffff;
        else if (phase == 2) d = r[0] ? 32'h0 : 32'h0;
        else d = r[0] ? random_four() : random_eta();
        write_reg(r, d);
      end
      if (phase < 3) begin
        foreach (directed[i]) cos_pending.push_back(directed[i]);
      end else begin
        send_idle_pct = (phase < 5) ? 36 : (phase < 7) ? 83 : 0;
        recv_idle_pct = (phase < 5) ? 83 : (phase < 7) ? 36 : 0;
        for (int i = 0; i < 200; i++) cos_pending.push_back(random_cos());
      end
      drain_pipeline();
    end

    if (mismatches == 0) $display("[conductor_fresnel_reflectance_top] OK");
    else $display("[conductor_fresnel_reflectance_top] ERROR");
    $finish;
  end

endmodule
